### src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

### src/ffc_pkg.sv
// ----------------------------------------------------------------------------
// ffc_pkg
// Types and codes shared by the flood fill canvas unit and its checker.
// ----------------------------------------------------------------------------
package ffc_pkg;

   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_FILL   = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;
   // spare code, behaves as a read
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [4:0] x_pos;
      logic [4:0] y_pos;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } ffc_req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       in_range;
   } ffc_rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SEED,
      ST_POP,
      ST_LOAD,
      ST_NBR,
      ST_CHECK,
      ST_READ,
      ST_FETCH
   } ffc_state_type;

   typedef enum logic [1:0] {
      DIR_UP,
      DIR_DOWN,
      DIR_LEFT,
      DIR_RIGHT
   } ffc_dir_type;

endpackage

### src/ffc_stream_if.sv
// ----------------------------------------------------------------------------
// ffc_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface ffc_stream_if #(
   parameter type payload_type = logic [7:0]
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### src/flood_fill_canvas_unit.sv
// ----------------------------------------------------------------------------
// flood_fill_canvas_unit
// RGB canvas with pixel write, pixel read and 4-connected flood fill.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one command beat: write, fill or read of pixel (x,y).
//   rsp_chan returns one beat per command: the pixel at (x,y) after the
//   command and an in-range flag. Out-of-range commands change nothing and
//   return black with the flag low.
// Sequencing:
//   out-of-range command: answered from idle; read and write: READ, FETCH.
//   fill: SEED (straight to READ when the color already matches), then POP
//   and LOAD per popped pixel and NBR and CHECK per neighbor, then READ and
//   FETCH; each popped pixel takes a stack read, a canvas write and a canvas
//   read per neighbor, through the single canvas and stack port pairs.
// Throughput:
//   one command at a time; req_chan.ready is high only while the sequencer
//   is idle and no response beat is waiting.
// Reset:
//   after reset the canvas is swept to black, one pixel per cycle, all
//   WIDTH*HEIGHT pixels (1024 by default); no command is taken meanwhile.
// Stall:
//   a response beat waits in its output register until rsp_chan.ready;
//   no new command is taken until it leaves.
// ----------------------------------------------------------------------------
module flood_fill_canvas_unit #(
   parameter int WIDTH       = 32,
   parameter int HEIGHT      = 32,
   parameter int STACK_DEPTH = 4096
) (
   input  logic         clock,
   input  logic         reset,
   ffc_stream_if.sink   req_chan,
   ffc_stream_if.source rsp_chan
);
   import ffc_pkg::*;

   localparam int NPIX = WIDTH * HEIGHT;
   localparam int IW   = $clog2(NPIX);
   localparam int XW   = $clog2(WIDTH);
   localparam int YW   = $clog2(HEIGHT);
   localparam int SW   = $clog2(STACK_DEPTH);
   localparam int CW   = $clog2(STACK_DEPTH + 1);
   localparam int EW   = YW + XW + IW;

   // Memories
   logic [23:0]   canvas_mem [NPIX];
   logic [EW-1:0] stack_mem  [STACK_DEPTH];

   // Control registers
   ffc_state_type state_ff, state_in;
   logic [IW-1:0] clr_ff;
   logic [CW-1:0] cnt_ff;
   logic          rsp_valid_ff;
   ffc_dir_type   dir_ff;

   // Payload registers
   logic [IW-1:0] seed_idx_ff;
   logic [IW-1:0] cur_idx_ff;
   logic [XW-1:0] cur_x_ff;
   logic [YW-1:0] cur_y_ff;
   logic [23:0]   color_ff;
   logic [23:0]   old_ff;
   logic [23:0]   cv_rd_ff;
   logic [EW-1:0] stk_rd_ff;
   ffc_rsp_type   rsp_data_ff;

   // Memory port controls
   logic          cv_we;
   logic [IW-1:0] cv_wa;
   logic [23:0]   cv_wd;
   logic [IW-1:0] cv_ra;
   logic          stk_we;
   logic [SW-1:0] stk_wa;
   logic [EW-1:0] stk_wd;
   logic [SW-1:0] stk_ra;

   // Decoded request and neighbor
   ffc_req_type   req;
   logic          acc;
   logic          req_ok;
   logic [IW-1:0] req_idx;
   logic [23:0]   req_color;
   logic          nb_ok;
   logic [IW-1:0] nb_idx;
   logic [XW-1:0] nb_x;
   logic [YW-1:0] nb_y;
   logic          push_ok;
   logic [CW-1:0] cnt_dec;

   assign req       = req_chan.data;
   assign acc       = req_chan.valid && req_chan.ready;
   assign req_ok    = (32'(req.x_pos) < WIDTH) && (32'(req.y_pos) < HEIGHT);
   assign req_idx   = IW'(32'(req.y_pos) * WIDTH + 32'(req.x_pos));
   assign req_color = {req.red, req.green, req.blue};
   assign push_ok   = (cv_rd_ff == old_ff) && (cnt_ff != CW'(STACK_DEPTH));
   assign cnt_dec   = cnt_ff - CW'(1);

   assign req_chan.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // Select the neighbor of the current pixel for this direction
   always_comb begin
      nb_ok  = 1'b0;
      nb_idx = cur_idx_ff;
      nb_x   = cur_x_ff;
      nb_y   = cur_y_ff;
      case (dir_ff)
         DIR_UP: begin
            nb_ok  = (cur_y_ff != '0);
            nb_idx = cur_idx_ff - IW'(WIDTH);
            nb_y   = cur_y_ff - YW'(1);
         end
         DIR_DOWN: begin
            nb_ok  = (32'(cur_y_ff) + 1 < HEIGHT);
            nb_idx = cur_idx_ff + IW'(WIDTH);
            nb_y   = cur_y_ff + YW'(1);
         end
         DIR_LEFT: begin
            nb_ok  = (cur_x_ff != '0);
            nb_idx = cur_idx_ff - IW'(1);
            nb_x   = cur_x_ff - XW'(1);
         end
         DIR_RIGHT: begin
            nb_ok  = (32'(cur_x_ff) + 1 < WIDTH);
            nb_idx = cur_idx_ff + IW'(1);
            nb_x   = cur_x_ff + XW'(1);
         end
         default: nb_ok = 1'b0;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == IW'(NPIX - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (acc && req_ok) begin
               state_in = (req.kind == KIND_FILL) ? ST_SEED : ST_READ;
            end
         end
         ST_SEED:  state_in = (cv_rd_ff == color_ff) ? ST_READ : ST_POP;
         ST_POP:   state_in = (cnt_ff == '0) ? ST_READ : ST_LOAD;
         ST_LOAD:  state_in = ST_NBR;
         ST_NBR: begin
            if (nb_ok) state_in = ST_CHECK;
            else if (dir_ff == DIR_RIGHT) state_in = ST_POP;
         end
         ST_CHECK: state_in = (dir_ff == DIR_RIGHT) ? ST_POP : ST_NBR;
         ST_READ:  state_in = ST_FETCH;
         ST_FETCH: state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   // Memory port controls
   always_comb begin
      cv_we  = 1'b0;
      cv_wa  = cur_idx_ff;
      cv_wd  = color_ff;
      cv_ra  = seed_idx_ff;
      stk_we = 1'b0;
      stk_wa = cnt_ff[SW-1:0];
      stk_wd = {nb_y, nb_x, nb_idx};
      stk_ra = cnt_dec[SW-1:0];
      unique case (state_ff)
         ST_CLEAR: begin
            cv_we = 1'b1;
            cv_wa = clr_ff;
            cv_wd = '0;
         end
         ST_IDLE: begin
            cv_ra = req_idx;
            if (acc && req_ok && req.kind == KIND_WRITE) begin
               cv_we = 1'b1;
               cv_wa = req_idx;
               cv_wd = req_color;
            end
         end
         ST_SEED: begin
            stk_we = (cv_rd_ff != color_ff);
            stk_wa = '0;
            stk_wd = {cur_y_ff, cur_x_ff, cur_idx_ff};
         end
         ST_POP: stk_ra = cnt_dec[SW-1:0];
         ST_LOAD: begin
            cv_we = 1'b1;
            cv_wa = stk_rd_ff[IW-1:0];
         end
         ST_NBR:   cv_ra = nb_idx;
         ST_CHECK: stk_we = push_ok;
         ST_READ:  cv_ra = seed_idx_ff;
         ST_FETCH: cv_we = 1'b0;
         default:  cv_we = 1'b0;
      endcase
   end

   // Canvas and stack memories with registered reads
   always_ff @(posedge clock) begin
      if (cv_we) canvas_mem[cv_wa] <= cv_wd;
      cv_rd_ff <= canvas_mem[cv_ra];
   end

   always_ff @(posedge clock) begin
      if (stk_we) stack_mem[stk_wa] <= stk_wd;
      stk_rd_ff <= stack_mem[stk_ra];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         dir_ff       <= DIR_UP;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + IW'(1);
         // drop the beat once taken, raise it when a result is ready
         if (rsp_valid_ff && rsp_chan.ready) rsp_valid_ff <= 1'b0;
         if ((state_ff == ST_IDLE && acc && !req_ok) || state_ff == ST_FETCH) begin
            rsp_valid_ff <= 1'b1;
         end
         // stack count and neighbor direction
         case (state_ff)
            ST_SEED:  if (cv_rd_ff != color_ff) cnt_ff <= CW'(1);
            ST_POP:   if (cnt_ff != '0) cnt_ff <= cnt_dec;
            ST_LOAD:  dir_ff <= DIR_UP;
            ST_NBR:   if (!nb_ok) dir_ff <= ffc_dir_type'(dir_ff + 2'd1);
            ST_CHECK: begin
               if (push_ok) cnt_ff <= cnt_ff + CW'(1);
               dir_ff <= ffc_dir_type'(dir_ff + 2'd1);
            end
            default: dir_ff <= dir_ff;
         endcase
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               seed_idx_ff <= req_idx;
               cur_idx_ff  <= req_idx;
               cur_x_ff    <= XW'(req.x_pos);
               cur_y_ff    <= YW'(req.y_pos);
               color_ff    <= req_color;
               if (!req_ok) rsp_data_ff <= '0;
            end
         end
         ST_SEED: old_ff <= cv_rd_ff;
         ST_LOAD: {cur_y_ff, cur_x_ff, cur_idx_ff} <= stk_rd_ff;
         ST_FETCH: begin
            rsp_data_ff.out_red   <= cv_rd_ff[23:16];
            rsp_data_ff.out_green <= cv_rd_ff[15:8];
            rsp_data_ff.out_blue  <= cv_rd_ff[7:0];
            rsp_data_ff.in_range  <= 1'b1;
         end
         default: old_ff <= old_ff;
      endcase
   end

endmodule

### src/ffc_checker.sv
// ----------------------------------------------------------------------------
// ffc_port_props
// Port-level checks on the flood fill canvas unit, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffc_port_props (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input ffc_pkg::ffc_rsp_type rsp_data
);
   import ffc_pkg::*;

   logic rsp_black;

   assign rsp_black = ({rsp_data.out_red, rsp_data.out_green, rsp_data.out_blue} == 24'd0);

   // A stalled response beat stays offered
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   // No command is taken while a response waits
   `ASSERT_CLK(a_one_at_a_time, clock, reset, rsp_valid |-> !(req_valid && req_ready))
   // Out-of-range responses are black
   `ASSERT_CLK(a_oor_black, clock, reset, rsp_valid && !rsp_data.in_range |-> rsp_black)
   // Reset empties the response register and blocks commands
   `ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid && !req_ready)

endmodule

bind flood_fill_canvas_unit ffc_port_props u_ffc_port_props (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);
